// ===== rtl/ialu_pkg.sv =====
`default_nettype none

package ialu_pkg;

    // operation codes
    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_DIV = 4'd1,
        OP_POW = 4'd2,
        OP_MUL = 4'd3,
        OP_SUB = 4'd4,
        OP_EQ  = 4'd5,
        OP_GE  = 4'd6,
        OP_GT  = 4'd7,
        OP_LE  = 4'd8,
        OP_LT  = 4'd9,
        OP_NE  = 4'd10,
        OP_REM = 4'd11
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        RES_OK      = 2'd0,
        RES_FALSE   = 2'd1,
        RES_ERROR   = 2'd2,
        RES_ILLEGAL = 2'd3
    } res_t;

    // which result the datapath captures at the end of an item
    typedef enum logic [2:0] {
        FIN_NONE,
        FIN_QUICK,
        FIN_MUL,
        FIN_DIV,
        FIN_POW,
        FIN_ERR
    } fin_t;

    // multiplier operand pair
    typedef enum logic [1:0] {
        MSEL_XY,
        MSEL_PB,
        MSEL_BB
    } msel_t;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_MUL,
        S_DIV,
        S_POW_CHECK,
        S_POW_MULP,
        S_POW_SHIFT,
        S_POW_SQR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [3:0]         op;
        logic signed [31:0] operand_x;
        logic signed [31:0] operand_y;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
        logic [31:0]        ops_done;
    } out_word_t;

    // controller to datapath
    typedef struct packed {
        logic  load;
        fin_t  fin;
        logic  mul_start;
        msel_t mul_sel;
        logic  mul_step;
        logic  div_start;
        logic  div_step;
        logic  pow_init;
        logic  p_load;
        logic  base_load;
        logic  e_shift;
        logic  push;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [3:0] op;
        logic       y_zero;
        logic       y_neg;
        logic       e_lsb;
        logic       e_next_zero;
        logic       mul_done;
        logic       mul_ok;
        logic       div_done;
        logic       out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/ialu_ctrl.sv =====
`default_nettype none

module ialu_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire ialu_pkg::sts_t sts,
    output ialu_pkg::cmd_t     cmd
);

    ialu_pkg::state_t state_reg;
    ialu_pkg::state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ialu_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ialu_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = ialu_pkg::S_DISPATCH;
                end
            end
            ialu_pkg::S_DISPATCH: begin
                case (sts.op)
                    ialu_pkg::OP_MUL: begin
                        state_next = ialu_pkg::S_MUL;
                    end
                    ialu_pkg::OP_DIV, ialu_pkg::OP_REM: begin
                        state_next = sts.y_zero ? ialu_pkg::S_DONE : ialu_pkg::S_DIV;
                    end
                    ialu_pkg::OP_POW: begin
                        state_next = sts.y_neg ? ialu_pkg::S_DONE : ialu_pkg::S_POW_CHECK;
                    end
                    default: begin
                        state_next = ialu_pkg::S_DONE;
                    end
                endcase
            end
            ialu_pkg::S_MUL: begin
                if (sts.mul_done) begin
                    state_next = ialu_pkg::S_DONE;
                end
            end
            ialu_pkg::S_DIV: begin
                if (sts.div_done) begin
                    state_next = ialu_pkg::S_DONE;
                end
            end
            ialu_pkg::S_POW_CHECK: begin
                state_next = sts.e_lsb ? ialu_pkg::S_POW_MULP : ialu_pkg::S_POW_SHIFT;
            end
            ialu_pkg::S_POW_MULP: begin
                if (sts.mul_done) begin
                    state_next = sts.mul_ok ? ialu_pkg::S_POW_SHIFT : ialu_pkg::S_DONE;
                end
            end
            ialu_pkg::S_POW_SHIFT: begin
                state_next = sts.e_next_zero ? ialu_pkg::S_DONE : ialu_pkg::S_POW_SQR;
            end
            ialu_pkg::S_POW_SQR: begin
                if (sts.mul_done) begin
                    state_next = sts.mul_ok ? ialu_pkg::S_POW_CHECK : ialu_pkg::S_DONE;
                end
            end
            ialu_pkg::S_DONE: begin
                if (sts.out_free) begin
                    state_next = ialu_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ialu_pkg::S_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        cmd         = '0;
        cmd.fin     = ialu_pkg::FIN_NONE;
        cmd.mul_sel = ialu_pkg::MSEL_XY;
        s_ready     = 1'b0;
        case (state_reg)
            ialu_pkg::S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ialu_pkg::S_DISPATCH: begin
                case (sts.op)
                    ialu_pkg::OP_MUL: begin
                        cmd.mul_start = 1'b1;
                    end
                    ialu_pkg::OP_DIV, ialu_pkg::OP_REM: begin
                        if (sts.y_zero) begin
                            cmd.fin = ialu_pkg::FIN_QUICK;
                        end else begin
                            cmd.div_start = 1'b1;
                        end
                    end
                    ialu_pkg::OP_POW: begin
                        if (sts.y_neg) begin
                            cmd.fin = ialu_pkg::FIN_QUICK;
                        end else begin
                            cmd.pow_init = 1'b1;
                        end
                    end
                    default: begin
                        cmd.fin = ialu_pkg::FIN_QUICK;
                    end
                endcase
            end
            ialu_pkg::S_MUL: begin
                if (sts.mul_done) begin
                    cmd.fin = ialu_pkg::FIN_MUL;
                end else begin
                    cmd.mul_step = 1'b1;
                end
            end
            ialu_pkg::S_DIV: begin
                if (sts.div_done) begin
                    cmd.fin = ialu_pkg::FIN_DIV;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ialu_pkg::S_POW_CHECK: begin
                if (sts.e_lsb) begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = ialu_pkg::MSEL_PB;
                end
            end
            ialu_pkg::S_POW_MULP: begin
                if (!sts.mul_done) begin
                    cmd.mul_step = 1'b1;
                end else if (sts.mul_ok) begin
                    cmd.p_load = 1'b1;
                end else begin
                    cmd.fin = ialu_pkg::FIN_ERR;
                end
            end
            ialu_pkg::S_POW_SHIFT: begin
                cmd.e_shift = 1'b1;
                if (sts.e_next_zero) begin
                    cmd.fin = ialu_pkg::FIN_POW;
                end else begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = ialu_pkg::MSEL_BB;
                end
            end
            ialu_pkg::S_POW_SQR: begin
                if (!sts.mul_done) begin
                    cmd.mul_step = 1'b1;
                end else if (sts.mul_ok) begin
                    cmd.base_load = 1'b1;
                end else begin
                    cmd.fin = ialu_pkg::FIN_ERR;
                end
            end
            ialu_pkg::S_DONE: begin
                cmd.push = sts.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/ialu_dp.sv =====
`default_nettype none

module ialu_dp #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire ialu_pkg::in_word_t  s_word,
    input  wire ialu_pkg::cmd_t      cmd,
    output ialu_pkg::sts_t           sts,
    output logic                     m_valid,
    output ialu_pkg::out_word_t      m_word,
    input  wire logic                m_ready
);

    localparam int W  = DATA_WIDTH;
    localparam int CW = $clog2(W + 1);
    localparam logic [W-1:0]   MIN_MAG = {1'b1, {(W-1){1'b0}}};
    localparam logic [2*W-1:0] LIM_NEG = {{W{1'b0}}, MIN_MAG};
    localparam logic [2*W-1:0] LIM_POS = LIM_NEG - (2*W)'(1);

    logic [W-1:0] in_x;
    logic [W-1:0] in_y;
    logic [31:0]  fin_val32;
    logic [W-1:0] fin_val;

    // operand width adaption and result width adaption
    generate
        if (W <= 32) begin : g_in_narrow
            assign in_x = s_word.operand_x[W-1:0];
            assign in_y = s_word.operand_y[W-1:0];
        end else begin : g_in_wide
            assign in_x = {{(W-32){s_word.operand_x[31]}}, s_word.operand_x};
            assign in_y = {{(W-32){s_word.operand_y[31]}}, s_word.operand_y};
        end
        if (W < 32) begin : g_out_narrow
            assign fin_val32 = {{(32-W){1'b0}}, fin_val};
        end else begin : g_out_wide
            assign fin_val32 = fin_val[31:0];
        end
    endgenerate

    logic [3:0]   op_reg;
    logic [W-1:0] x_reg;
    logic [W-1:0] y_reg;

    // operand capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= s_word.op;
            x_reg  <= in_x;
            y_reg  <= in_y;
        end
    end

    // combinational operations
    logic [W-1:0]   sum;
    logic [W-1:0]   diff;
    logic           add_ovf;
    logic           sub_ovf;
    logic           lt_s;
    logic           eq;
    logic [W-1:0]   q_val;
    ialu_pkg::res_t q_status;
    logic           q_count;

    assign sum     = x_reg + y_reg;
    assign diff    = x_reg - y_reg;
    assign add_ovf = ((x_reg[W-1] ^ sum[W-1]) & (y_reg[W-1] ^ sum[W-1]));
    assign sub_ovf = ((x_reg[W-1] ^ y_reg[W-1]) & (x_reg[W-1] ^ diff[W-1]));
    assign lt_s    = $signed(x_reg) < $signed(y_reg);
    assign eq      = (x_reg == y_reg);

    always_comb begin
        q_val    = '0;
        q_status = ialu_pkg::RES_ERROR;
        q_count  = 1'b0;
        case (op_reg)
            ialu_pkg::OP_ADD: begin
                if (!add_ovf) begin
                    q_val    = sum;
                    q_status = ialu_pkg::RES_OK;
                    q_count  = 1'b1;
                end
            end
            ialu_pkg::OP_SUB: begin
                if (!sub_ovf) begin
                    q_val    = diff;
                    q_status = ialu_pkg::RES_OK;
                    q_count  = 1'b1;
                end
            end
            ialu_pkg::OP_EQ: q_status = eq ? ialu_pkg::RES_OK : ialu_pkg::RES_FALSE;
            ialu_pkg::OP_GE: q_status = !lt_s ? ialu_pkg::RES_OK : ialu_pkg::RES_FALSE;
            ialu_pkg::OP_GT: begin
                q_status = (!lt_s && !eq) ? ialu_pkg::RES_OK : ialu_pkg::RES_FALSE;
            end
            ialu_pkg::OP_LE: begin
                q_status = (lt_s || eq) ? ialu_pkg::RES_OK : ialu_pkg::RES_FALSE;
            end
            ialu_pkg::OP_LT: q_status = lt_s ? ialu_pkg::RES_OK : ialu_pkg::RES_FALSE;
            ialu_pkg::OP_NE: q_status = !eq ? ialu_pkg::RES_OK : ialu_pkg::RES_FALSE;
            // negative exponent: zero, unless the base is zero
            ialu_pkg::OP_POW: begin
                if (x_reg != '0) begin
                    q_status = ialu_pkg::RES_OK;
                    q_count  = 1'b1;
                end
            end
            // divide by zero
            ialu_pkg::OP_DIV, ialu_pkg::OP_REM, ialu_pkg::OP_MUL: begin
                q_status = ialu_pkg::RES_ERROR;
            end
            default: q_status = ialu_pkg::RES_ILLEGAL;
        endcase
    end

    // shared shift-add multiplier on magnitudes, stops when the multiplier runs out of ones
    logic [W-1:0]   p_reg;
    logic [W-1:0]   base_reg;
    logic [W-1:0]   e_reg;
    logic [W-1:0]   a_sel;
    logic [W-1:0]   b_sel;
    logic [W-1:0]   mag_a;
    logic [W-1:0]   mag_b;
    logic [2*W-1:0] acc_reg;
    logic [2*W-1:0] mcand_reg;
    logic [W-1:0]   mplier_reg;
    logic           mneg_reg;
    logic           mul_ok;
    logic [W-1:0]   mul_val;

    always_comb begin
        case (cmd.mul_sel)
            ialu_pkg::MSEL_PB: begin
                a_sel = p_reg;
                b_sel = base_reg;
            end
            ialu_pkg::MSEL_BB: begin
                a_sel = base_reg;
                b_sel = base_reg;
            end
            default: begin
                a_sel = x_reg;
                b_sel = y_reg;
            end
        endcase
    end

    assign mag_a = a_sel[W-1] ? -a_sel : a_sel;
    assign mag_b = b_sel[W-1] ? -b_sel : b_sel;

    always_ff @(posedge aclk) begin
        if (cmd.mul_start) begin
            acc_reg    <= '0;
            mcand_reg  <= {{W{1'b0}}, mag_a};
            mplier_reg <= mag_b;
            mneg_reg   <= a_sel[W-1] ^ b_sel[W-1];
        end else if (cmd.mul_step) begin
            if (mplier_reg[0]) begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign mul_ok  = mneg_reg ? (acc_reg <= LIM_NEG) : (acc_reg <= LIM_POS);
    assign mul_val = mneg_reg ? -acc_reg[W-1:0] : acc_reg[W-1:0];

    // square-and-multiply registers
    always_ff @(posedge aclk) begin
        if (cmd.pow_init) begin
            p_reg    <= W'(1);
            base_reg <= x_reg;
            e_reg    <= y_reg;
        end else begin
            if (cmd.p_load) begin
                p_reg <= mul_val;
            end
            if (cmd.base_load) begin
                base_reg <= mul_val;
            end
            if (cmd.e_shift) begin
                e_reg <= e_reg >> 1;
            end
        end
    end

    // restoring divider, one quotient bit a cycle
    logic [W-1:0]  mag_x;
    logic [W-1:0]  mag_y;
    logic [W-1:0]  dvs_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  rem_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  shifted;
    logic [W:0]    trial;
    logic          qneg;
    logic          q_ok;
    logic [W-1:0]  d_val;

    assign mag_x   = x_reg[W-1] ? -x_reg : x_reg;
    assign mag_y   = y_reg[W-1] ? -y_reg : y_reg;
    assign shifted = {rem_reg[W-2:0], quo_reg[W-1]};
    assign trial   = {1'b0, shifted} - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            dvs_reg <= mag_y;
            quo_reg <= mag_x;
            rem_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            if (!trial[W]) begin
                rem_reg <= trial[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

    // quotient overflows only for most negative by minus one
    assign qneg  = x_reg[W-1] ^ y_reg[W-1];
    assign q_ok  = !quo_reg[W-1] || (qneg && (quo_reg[W-2:0] == '0));
    assign d_val = (op_reg == ialu_pkg::OP_REM) ? (x_reg[W-1] ? -rem_reg : rem_reg)
                                                : (qneg ? -quo_reg : quo_reg);

    // finish selection
    ialu_pkg::res_t fin_status;
    logic           fin_count;

    always_comb begin
        fin_val    = '0;
        fin_status = ialu_pkg::RES_ERROR;
        fin_count  = 1'b0;
        case (cmd.fin)
            ialu_pkg::FIN_QUICK: begin
                fin_val    = q_val;
                fin_status = q_status;
                fin_count  = q_count;
            end
            ialu_pkg::FIN_MUL: begin
                if (mul_ok) begin
                    fin_val    = mul_val;
                    fin_status = ialu_pkg::RES_OK;
                    fin_count  = 1'b1;
                end
            end
            ialu_pkg::FIN_DIV: begin
                if (q_ok) begin
                    fin_val    = d_val;
                    fin_status = ialu_pkg::RES_OK;
                    fin_count  = 1'b1;
                end
            end
            ialu_pkg::FIN_POW: begin
                fin_val    = p_reg;
                fin_status = ialu_pkg::RES_OK;
                fin_count  = 1'b1;
            end
            default: begin
                fin_status = ialu_pkg::RES_ERROR;
            end
        endcase
    end

    logic [31:0] res_value_reg;
    logic [1:0]  res_status_reg;
    logic [31:0] arith_count_reg;

    // result capture
    always_ff @(posedge aclk) begin
        if (cmd.fin != ialu_pkg::FIN_NONE) begin
            res_value_reg  <= fin_val32;
            res_status_reg <= fin_status;
        end
    end

    // successful arithmetic counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arith_count_reg <= '0;
        end else if ((cmd.fin != ialu_pkg::FIN_NONE) && fin_count) begin
            arith_count_reg <= arith_count_reg + 32'd1;
        end
    end

    // output register
    logic                m_valid_reg;
    ialu_pkg::out_word_t m_word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            m_word_reg.value    <= res_value_reg;
            m_word_reg.status   <= res_status_reg;
            m_word_reg.ops_done <= arith_count_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    // status to controller
    assign sts.op          = op_reg;
    assign sts.y_zero      = (y_reg == '0);
    assign sts.y_neg       = y_reg[W-1];
    assign sts.e_lsb       = e_reg[0];
    assign sts.e_next_zero = (e_reg[W-1:1] == '0);
    assign sts.mul_done    = (mplier_reg == '0);
    assign sts.mul_ok      = mul_ok;
    assign sts.div_done    = (cnt_reg == CW'(W));
    assign sts.out_free    = !m_valid_reg || m_ready;

endmodule

`default_nettype wire

// ===== rtl/integer_alu_with_power.sv =====
`default_nettype none

// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+--------------------------------
// s_       | in        | s_valid / s_ready  | s_word: op, operand_x, operand_y
// m_       | out       | m_valid / m_ready  | m_word: value, status, ops_done
//
// one word is in work at a time; s_ready is high while the controller is idle
// add, sub, compares and illegal ops finish in the dispatch state, with no arithmetic unit
// mul: one step of the one-bit-a-cycle multiplier per bit of |operand_y|
// div, rem: one quotient bit per step of the restoring divider; pow: one multiplier
// pass per set exponent bit and per squaring
// aresetn clears the controller, the output valid and the success counter
// a finished result waits in the output register; a second result waits in the
// datapath until m_ready frees that register

module integer_alu_with_power #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire ialu_pkg::in_word_t  s_word,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output ialu_pkg::out_word_t      m_word
);

    ialu_pkg::cmd_t cmd;
    ialu_pkg::sts_t sts;

    // sequencer
    ialu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // operand, arithmetic and output registers
    ialu_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_word  (s_word),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_word  (m_word),
        .m_ready (m_ready)
    );

endmodule

`default_nettype wire
